// File: rtl/swic_pkg.sv
// Shared constants, types and command/status structs of the sliding window
// inversion counter. No dependencies; every other file of the block imports it.
`default_nettype none

package swic_pkg;

    localparam int VALUE_BITS = 8;
    localparam int MAX_WINDOW = 256;

    localparam int CFG_W     = 9;                          // window_size field
    localparam int IN_W      = 8;                          // sample_value field
    localparam int OUT_W     = 15;                         // inversion_count field
    localparam int TREE_SIZE = 1 << VALUE_BITS;
    localparam int IDX_W     = VALUE_BITS + 2;             // walk index, room for overshoot
    localparam int CNT_W     = $clog2(MAX_WINDOW + 2);     // window plus the new value
    localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
    localparam int RING_AW   = $clog2(MAX_WINDOW);

    typedef enum logic [1:0] {
        WALK_QUERY,
        WALK_ADD,
        WALK_SUB
    } t_walk_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QNEW,
        S_QNEW_W,
        S_ADD,
        S_ADD_W,
        S_QOLD,
        S_QOLD_W,
        S_SUB,
        S_SUB_W,
        S_DONE
    } t_state;

    typedef struct packed {
        logic     accept;
        logic     walk_start;
        t_walk_op walk_op;
        logic     walk_old;     // walk starts from the oldest value, else the new one
        logic     acc_new;
        logic     acc_old;
        logic     load_out;
        logic     commit;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_busy;
        logic drop;
        logic emit;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/swic_if.sv
// Handshake channels of the inversion counter: sample input, result output
// and the window size write port. Depends on swic_pkg.
`default_nettype none

interface swic_in_if;
    import swic_pkg::*;
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] sample_value;
    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

interface swic_out_if;
    import swic_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] inversion_count;
    modport source (output valid, output inversion_count, input ready);
    modport sink (input valid, input inversion_count, output ready);
endinterface

interface swic_cfg_if;
    import swic_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] window_size;
    modport source (output valid, output window_size, input ready);
    modport sink (input valid, input window_size, output ready);
endinterface

`default_nettype wire

// File: rtl/swic_ctrl.sv
// Sequencer of the inversion counter: runs the two or four tree walks of one word.
// Depends on swic_pkg; drives the datapath swic_dp through t_dp_cmd.
`default_nettype none

module swic_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output swic_pkg::t_dp_cmd   o_cmd,
    input  swic_pkg::t_dp_stat  i_stat
);
    import swic_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.walk_op = WALK_QUERY;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_QNEW;
                end
            end
            S_QNEW: begin
                o_cmd.walk_start = 1'b1;
                o_cmd.walk_op    = WALK_QUERY;
                n_state          = S_QNEW_W;
            end
            S_QNEW_W: begin
                if (!i_stat.walk_busy) begin
                    o_cmd.acc_new = 1'b1;
                    n_state       = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.walk_start = 1'b1;
                o_cmd.walk_op    = WALK_ADD;
                n_state          = S_ADD_W;
            end
            S_ADD_W: begin
                if (!i_stat.walk_busy) begin
                    n_state = i_stat.drop ? S_QOLD : S_DONE;
                end
            end
            S_QOLD: begin
                o_cmd.walk_start = 1'b1;
                o_cmd.walk_op    = WALK_QUERY;
                o_cmd.walk_old   = 1'b1;
                n_state          = S_QOLD_W;
            end
            S_QOLD_W: begin
                if (!i_stat.walk_busy) begin
                    o_cmd.acc_old = 1'b1;
                    n_state       = S_SUB;
                end
            end
            S_SUB: begin
                o_cmd.walk_start = 1'b1;
                o_cmd.walk_op    = WALK_SUB;
                o_cmd.walk_old   = 1'b1;
                n_state          = S_SUB_W;
            end
            S_SUB_W: begin
                if (!i_stat.walk_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold here while a new result is due and the previous one has not been taken
                if (!i_stat.emit) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.commit   = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/swic_dp.sv
// Datapath of the inversion counter: sample ring, Fenwick count tree with its
// walk engine, running count and result register. Depends on swic_pkg.
`default_nettype none

module swic_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  swic_pkg::t_dp_cmd            i_cmd,
    output swic_pkg::t_dp_stat           o_stat,
    input  wire [swic_pkg::IN_W-1:0]     i_sample_value,
    input  wire                          i_cfg_valid,
    input  wire [swic_pkg::CFG_W-1:0]    i_cfg_window_size,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [swic_pkg::OUT_W-1:0]   o_inversion_count
);
    import swic_pkg::*;

    localparam logic [IDX_W-1:0] TREE_LAST = IDX_W'(TREE_SIZE);

    // configuration and window bookkeeping
    logic [CFG_W-1:0]      r_window_size;
    logic [WIN_W-1:0]      win;
    logic [WIN_W-1:0]      r_count;
    logic [WIN_W:0]        count_plus;
    logic [WIN_W-1:0]      final_count;
    logic [RING_AW-1:0]    r_ptr;
    logic [VALUE_BITS-1:0] r_value;
    logic [OUT_W-1:0]      r_running;

    // sample ring
    logic [VALUE_BITS-1:0] ring_mem [MAX_WINDOW];
    logic [VALUE_BITS-1:0] r_ring_q;
    logic [RING_AW-1:0]    oldest_addr;

    // count tree and walk engine
    logic [CNT_W-1:0]      tree_mem [TREE_SIZE];
    logic [TREE_SIZE-1:0]  r_tree_vld;
    logic [CNT_W-1:0]      r_tree_q;
    logic [IDX_W-1:0]      r_idx;
    t_walk_op              r_op;
    logic                  r_pend;
    logic [VALUE_BITS-1:0] r_pidx;
    logic [CNT_W-1:0]      r_sum;
    logic                  active;
    logic [IDX_W-1:0]      next_idx;
    logic [IDX_W-1:0]      start_idx;
    logic [VALUE_BITS-1:0] start_src;
    logic [CNT_W-1:0]      node;
    logic [CNT_W-1:0]      node_new;
    logic                  tree_we;

    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_count;

    // saturate the window size to 1..MAX_WINDOW
    always_comb begin
        if (r_window_size == '0) begin
            win = WIN_W'(1);
        end else if (r_window_size > CFG_W'(MAX_WINDOW)) begin
            win = WIN_W'(MAX_WINDOW);
        end else begin
            win = r_window_size[WIN_W-1:0];
        end
    end

    assign count_plus  = {1'b0, r_count} + (WIN_W+1)'(1);
    assign final_count = (count_plus > {1'b0, win}) ? r_count : count_plus[WIN_W-1:0];
    assign oldest_addr = r_ptr - r_count[RING_AW-1:0];

    always_comb begin
        o_stat.drop      = count_plus > {1'b0, win};
        o_stat.emit      = final_count >= win;
        o_stat.out_free  = !r_out_valid || i_out_ready;
        o_stat.walk_busy = active || r_pend;
    end

    // walk index: query strips the low bit, update climbs by it
    always_comb begin
        start_src = i_cmd.walk_old ? r_ring_q : r_value;
        if (i_cmd.walk_op == WALK_QUERY && i_cmd.walk_old) begin
            start_idx = IDX_W'(start_src);
        end else begin
            start_idx = IDX_W'(start_src) + IDX_W'(1);
        end
        if (r_op == WALK_QUERY) begin
            active   = r_idx != '0;
            next_idx = r_idx & (r_idx - IDX_W'(1));
        end else begin
            active   = (r_idx != '0) && (r_idx <= TREE_LAST);
            next_idx = r_idx + (r_idx & (~r_idx + IDX_W'(1)));
        end
        node = r_tree_vld[r_pidx] ? r_tree_q : '0;
        case (r_op)
            WALK_ADD: node_new = node + CNT_W'(1);
            WALK_SUB: node_new = node - CNT_W'(1);
            default:  node_new = node;
        endcase
        tree_we = r_pend && !i_cmd.walk_start && (r_op != WALK_QUERY);
    end

    // memories: read data registered, write through the same port timing
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            ring_mem[r_ptr] <= i_sample_value[VALUE_BITS-1:0];
            r_ring_q        <= ring_mem[oldest_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_tree_q <= tree_mem[r_idx[VALUE_BITS-1:0]];
        if (tree_we) begin
            tree_mem[r_pidx] <= node_new;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= CFG_W'(8);
            r_count       <= '0;
            r_ptr         <= '0;
            r_running     <= '0;
            r_tree_vld    <= '0;
            r_pend        <= 1'b0;
            r_op          <= WALK_QUERY;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_window_size <= i_cfg_window_size;
            end
            if (i_cmd.accept) begin
                r_ptr <= r_ptr + RING_AW'(1);
            end
            if (i_cmd.commit) begin
                r_count <= final_count;
            end
            if (i_cmd.acc_new) begin
                r_running <= r_running + OUT_W'(r_count) - OUT_W'(r_sum);
            end else if (i_cmd.acc_old) begin
                r_running <= r_running - OUT_W'(r_sum);
            end
            if (tree_we) begin
                r_tree_vld[r_pidx] <= 1'b1;
            end
            if (i_cmd.walk_start) begin
                r_idx  <= start_idx;
                r_op   <= i_cmd.walk_op;
                r_pend <= 1'b0;
            end else begin
                r_pend <= active;
                if (active) begin
                    r_idx <= next_idx;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_value <= i_sample_value[VALUE_BITS-1:0];
        end
        if (i_cmd.walk_start) begin
            r_sum <= '0;
        end else if (r_pend && r_op == WALK_QUERY) begin
            r_sum <= r_sum + node;
        end
        if (!i_cmd.walk_start && active) begin
            r_pidx <= r_idx[VALUE_BITS-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_count <= r_running;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_inversion_count = r_out_count;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_start |-> !o_stat.walk_busy)
        else $error("tree walk started while another is running");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= WIN_W'(MAX_WINDOW))
        else $error("window count beyond ring depth");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tree_we && active) |-> (r_pidx != r_idx[VALUE_BITS-1:0]))
        else $error("tree node read while its update is pending");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// File: rtl/sliding_window_inversion_counter_unit.sv
// Sliding window inversion counter, top level: one sample word in, one count word
// out once the window is full. From input accept to result it runs two or four
// Fenwick walks (new value, then the oldest when it drops out), then one load.
// Words are handled one at a time, not overlapped; the next sample is taken once idle,
// even while the last result still waits, unless a second result must hold for it.
// Synchronous active-low reset clears tree valid bits, ring pointer and both counts.
`default_nettype none

module sliding_window_inversion_counter_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    swic_in_if.sink     i_sample_ch,
    swic_cfg_if.sink    i_cfg_ch,
    swic_out_if.source  o_count_ch
);
    import swic_pkg::*;

    // command and status between the sequencer and the datapath
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    // window size register always writable; user makes writes land while idle, unchecked
    assign i_cfg_ch.ready    = 1'b1;
    assign i_sample_ch.ready = in_ready;

    // sequencer: accept, query new, add new, then query and remove the oldest
    // value when the window runs over, and hand the count out once the window is full
    swic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample_ch.valid),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // datapath: ring of recent samples, count tree, running count, result register
    swic_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_sample_value    (i_sample_ch.sample_value),
        .i_cfg_valid       (i_cfg_ch.valid),
        .i_cfg_window_size (i_cfg_ch.window_size),
        .o_out_valid       (o_count_ch.valid),
        .i_out_ready       (o_count_ch.ready),
        .o_inversion_count (o_count_ch.inversion_count)
    );

endmodule

`default_nettype wire

// File: tb/sliding_window_inversion_counter_unit_test.sv
`timescale 1ns / 1ps
// Self-checking regression for the sliding window inversion counter unit: a local
// count model predicts every count word, a checker compares them as they leave.
// Depends on swic_pkg, the swic channel interfaces and the unit's RTL.

module sliding_window_inversion_counter_unit_test;
    import swic_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 60;
    localparam int LONG_HOLD      = 600;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int RANDOM_SAMPLES = 30;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_PATTERN, SINK_SLOW} t_sink_mode;
    typedef enum {VALS_UNIFORM, VALS_NARROW, VALS_EXTREME, VALS_RAMP} t_value_mode;

    logic clk = 1'b0;
    logic rst_n;

    swic_in_if  sample_ch ();
    swic_cfg_if cfg_ch ();
    swic_out_if count_ch ();

    sliding_window_inversion_counter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_sample_ch (sample_ch),
        .i_cfg_ch    (cfg_ch),
        .o_count_ch  (count_ch)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Count model: a copy of the window ring, a tally per value, the number
    // of values held and the running count of inversions.
    // ------------------------------------------------------------------
    logic [IN_W-1:0]    ring_copy [MAX_WINDOW];
    logic [RING_AW-1:0] ring_head;
    int unsigned        value_tally [TREE_SIZE];
    int unsigned        held;
    logic [OUT_W-1:0]   inversions;
    logic [CFG_W-1:0]   window_reg;
    logic [OUT_W-1:0]   pending_counts [$];

    int samples_sent      = 0;
    int counts_checked    = 0;
    int mismatches        = 0;
    int settings_written  = 0;
    int peak_count        = 0;
    int cycle_count       = 0;
    int burst_left        = 5;
    int long_holds_asked  = 0;
    int long_holds_served = 0;

    function automatic int unsigned tally_below(input int unsigned v);
        int unsigned sum = 0;
        for (int i = 0; i < v; i++) sum += value_tally[i];
        return sum;
    endfunction

    // Fold one accepted sample into the model and queue the count word it causes.
    function automatic void absorb_sample(input logic [IN_W-1:0] v);
        int unsigned      span;
        int unsigned      oldest_slot;
        logic [IN_W-1:0]  oldest;
        span = 32'(window_reg);
        if (span < 1) span = 1;
        if (span > MAX_WINDOW) span = MAX_WINDOW;
        // Read the oldest value first: on a full ring its slot is about to be reused.
        oldest_slot = (32'(ring_head) + MAX_WINDOW - held) % MAX_WINDOW;
        oldest = ring_copy[oldest_slot[RING_AW-1:0]];
        // Every held value strictly above the new one forms a pair with it.
        inversions = inversions + OUT_W'(held - tally_below(32'(v) + 1));
        value_tally[v]++;
        ring_copy[ring_head] = v;
        ring_head = ring_head + 1'b1;
        held++;
        // Drop at most one oldest value, taking its pairs with smaller values along.
        if (held > span) begin
            inversions = inversions - OUT_W'(tally_below(32'(oldest)));
            value_tally[oldest]--;
            held--;
        end
        if (held >= span) begin
            pending_counts.push_back(inversions);
            if (32'(inversions) > peak_count) peak_count = 32'(inversions);
        end
    endfunction

    function automatic logic [IN_W-1:0] next_value(input t_value_mode mode,
                                                   input logic [IN_W-1:0] prev,
                                                   input logic [IN_W-1:0] base);
        logic [IN_W-1:0] step;
        step = IN_W'($urandom_range(0, 5));
        case (mode)
            VALS_UNIFORM: return IN_W'($urandom_range(0, TREE_SIZE - 1));
            VALS_NARROW:  return base + IN_W'($urandom_range(0, 3));     // many equal values
            VALS_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return IN_W'(1);
                    default: return IN_W'(TREE_SIZE - 2);
                endcase
            end
            default: begin
                // Mostly falling ramps pile up inversions; wrap gives a big jump.
                if ($urandom_range(0, 3) == 0) return prev + step;
                return prev - step;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall on a pattern of its own, honor long hold requests.
    // ------------------------------------------------------------------
    initial begin : count_sink
        t_sink_mode mode;
        int         mode_left;
        int         hold_left;
        int         beat;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        beat      = 0;
        count_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            beat++;
            if (hold_left > 0) begin
                count_ch.ready <= 1'b0;
                hold_left--;
            end else if (long_holds_served != long_holds_asked) begin
                // Hold the output shut for a long stretch so the unit backs up.
                long_holds_served = long_holds_asked;
                hold_left = LONG_HOLD - 1;
                count_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_sink_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:    count_ch.ready <= 1'b1;
                    SINK_COIN:    count_ch.ready <= 1'($urandom_range(0, 1));
                    SINK_PATTERN: count_ch.ready <= (beat % 7) > 2;
                    default:      count_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare each count word that leaves with the oldest prediction.
    always @(posedge clk) begin : count_checker
        logic [OUT_W-1:0] want;
        if (rst_n === 1'b1 && count_ch.valid === 1'b1 && count_ch.ready === 1'b1) begin
            if (pending_counts.size() == 0) begin
                mismatches++;
                $display("%0t: inversion_count word with nothing expected: actual %0d",
                         $time, count_ch.inversion_count);
            end else begin
                want = pending_counts.pop_front();
                counts_checked++;
                if (count_ch.inversion_count !== want) begin
                    mismatches++;
                    $display("%0t: inversion_count mismatch: expected %0d, actual %0d",
                             $time, want, count_ch.inversion_count);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sliding_window_inversion_counter_unit regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sample side
    // ------------------------------------------------------------------

    // Offer one word and hold it until accepted; valid stays high for the next word.
    task automatic send_sample(input logic [IN_W-1:0] v);
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_value <= v;
        do @(posedge clk); while (sample_ch.ready !== 1'b1);
        absorb_sample(v);
        samples_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        sample_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Send in bursts of random length with random gaps, now and then a long burst.
    task automatic stream_sample(input logic [IN_W-1:0] v);
        send_sample(v);
        burst_left--;
        if (burst_left <= 0) begin
            pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(9, 60)
                                                      : $urandom_range(1, 8));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // Drop valid, wait until every predicted word has left, then let any
    // silent item finish inside the unit.
    task automatic wait_for_counts();
        sample_ch.valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] size);
        wait_for_counts();
        cfg_ch.valid       <= 1'b1;
        cfg_ch.window_size <= size;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        window_reg = size;
        settings_written++;
    endtask

    // ------------------------------------------------------------------
    // Tests. The window only grows while samples flow, so the small sizes
    // come first, straight after reset.
    // ------------------------------------------------------------------

    // Zero saturates to one, then one and two.
    task automatic test_window_limits();
        write_window('0);
        send_sample(8'd255);
        send_sample(8'd0);
        send_sample(8'd128);
        write_window(CFG_W'(1));
        send_sample(8'd0);
        send_sample(8'd255);
        write_window(CFG_W'(2));
        send_sample(8'd255);
        send_sample(8'd0);
        send_sample(8'd0);
        send_sample(8'd255);
    endtask

    // Extremes, equal values, alternation and a falling run at window eight.
    task automatic test_directed_values();
        logic [IN_W-1:0] seq [20] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd128, 8'd128,
                                      8'd1, 8'd254, 8'd127, 8'd0, 8'd255, 8'd64, 8'd32,
                                      8'd16, 8'd8, 8'd4, 8'd2, 8'd1, 8'd0};
        write_window(CFG_W'(8));
        foreach (seq[i]) stream_sample(seq[i]);
    endtask

    // Keep offering words while the output is held shut, then drain fully.
    task automatic test_output_backpressure();
        write_window(CFG_W'(3));
        long_holds_asked <= long_holds_asked + 1;
        repeat (20) send_sample(IN_W'($urandom_range(0, TREE_SIZE - 1)));
        wait_for_counts();
    endtask

    // Grow, shrink and grow again mid-stream.
    task automatic test_window_resize();
        write_window(CFG_W'(12));
        repeat (20) stream_sample(IN_W'($urandom_range(0, TREE_SIZE - 1)));
        write_window(CFG_W'(4));
        repeat (12) stream_sample(IN_W'($urandom_range(0, TREE_SIZE - 1)));
        write_window(CFG_W'(20));
        repeat (25) stream_sample(IN_W'($urandom_range(0, TREE_SIZE - 1)));
    endtask

    // Segments of random length, each with its own window size and value shape.
    task automatic test_random_stream();
        int              sent;
        int              seg_len;
        t_value_mode     mode;
        logic [IN_W-1:0] v;
        logic [IN_W-1:0] base;
        logic [CFG_W-1:0] size;
        sent = 0;
        while (sent < RANDOM_SAMPLES) begin
            case ($urandom_range(0, 7))
                0:       size = '0;
                1, 2:    size = CFG_W'($urandom_range(1, 4));
                3, 4, 5: size = CFG_W'($urandom_range(5, 24));
                default: size = CFG_W'($urandom_range(25, 64));
            endcase
            write_window(size);
            mode    = t_value_mode'($urandom_range(0, 3));
            seg_len = $urandom_range(10, 30);
            base    = IN_W'($urandom_range(0, TREE_SIZE - 4));
            v       = IN_W'($urandom_range(0, TREE_SIZE - 1));
            repeat (seg_len) begin
                v = next_value(mode, v, base);
                stream_sample(v);
                sent++;
            end
        end
    endtask

    // Fill the full ring with a falling run for the largest count, slide it,
    // then the top size and an oversized one.
    task automatic test_full_window();
        logic [IN_W-1:0] v;
        write_window(CFG_W'(300));
        for (int i = TREE_SIZE - 1; i >= 0; i--) stream_sample(IN_W'(i));
        v = IN_W'($urandom_range(0, TREE_SIZE - 1));
        repeat (30) begin
            v = next_value(VALS_UNIFORM, v, v);
            stream_sample(v);
        end
        write_window(CFG_W'(MAX_WINDOW));
        repeat (6) stream_sample(IN_W'($urandom_range(0, TREE_SIZE - 1)));
        write_window({CFG_W{1'b1}});
        repeat (6) stream_sample(IN_W'($urandom_range(0, TREE_SIZE - 1)));
    endtask

    initial begin : regression
        rst_n                  = 1'b0;
        sample_ch.valid        = 1'b0;
        sample_ch.sample_value = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.window_size     = '0;
        foreach (ring_copy[i]) ring_copy[i] = '0;
        foreach (value_tally[i]) value_tally[i] = 0;
        ring_head  = '0;
        held       = 0;
        inversions = '0;
        window_reg = CFG_W'(8);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_window_limits();
        test_directed_values();
        test_output_backpressure();
        test_window_resize();
        test_random_stream();
        test_full_window();
        wait_for_counts();

        $display("covered %0d samples over %0d window settings, %0d count words checked",
                 samples_sent, settings_written, counts_checked);
        $display("peak count %0d, one output hold of %0d cycles, %0d mismatches",
                 peak_count, LONG_HOLD, mismatches);
        if (mismatches == 0) begin
            $display("sliding_window_inversion_counter_unit regression: pass");
        end else begin
            $display("sliding_window_inversion_counter_unit regression: fail");
        end
        $finish;
    end

endmodule
